// ===== rtl/vtpp_pkg.sv =====
// Shared constants and types for the vertex transform and projection unit.
// Used by vtpp_sine, vtpp_div, the top level and the testbench; depends on nothing.
`default_nettype none
package vtpp_pkg;

   // Angle quantization default (steps per full turn)
   localparam int unsigned SINE_TABLE_DEPTH_DEFAULT = 1024;

   // pi/2 in Q2.30 and the number of odd Taylor terms past the first
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
   localparam int unsigned SINE_STEPS  = 5;
   localparam int unsigned TRIG_W      = 18;

   // Projection divider: quotient bits kept before saturation
   localparam int unsigned QUO_BITS    = 17;
   localparam int unsigned DIV_LATENCY = QUO_BITS + 3;

   // Register stages ahead of the divider, and total item latency
   localparam int unsigned FRONT_STAGES = 6;
   localparam int unsigned LATENCY      = FRONT_STAGES + DIV_LATENCY;

   // Cycles the sine/cosine path needs to settle after an angle change
   localparam int unsigned SETTLE_W      = 5;
   localparam logic [4:0]  SETTLE_CYCLES = 5'd24;

   // Configuration register map
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [2:0] REG_ANGLE_PHASE   = 3'd0;
   localparam logic [2:0] REG_SCALE_FACTOR  = 3'd1;
   localparam logic [2:0] REG_OFFSET_X      = 3'd2;
   localparam logic [2:0] REG_OFFSET_Y      = 3'd3;
   localparam logic [2:0] REG_OFFSET_Z      = 3'd4;
   localparam logic [2:0] REG_FOV_FACTOR    = 3'd5;
   localparam logic [2:0] REG_WINDOW_WIDTH  = 3'd6;
   localparam logic [2:0] REG_WINDOW_HEIGHT = 3'd7;

   // Register reset values
   localparam logic [15:0] ANGLE_RESET  = 16'd0;
   localparam logic [31:0] SCALE_RESET  = 32'd65536;
   localparam logic [31:0] OFFSET_RESET = 32'd0;
   localparam logic [31:0] FOV_RESET    = 32'd65536;
   localparam logic [12:0] WIDTH_RESET  = 13'd640;
   localparam logic [12:0] HEIGHT_RESET = 13'd480;

   // Screen coordinate limits
   localparam logic signed [15:0] SCREEN_MAX = 16'sh7fff;
   localparam logic signed [15:0] SCREEN_MIN = 16'sh8000;

   // Side information that travels with each projection division
   typedef struct packed {
      logic        a_pos;
      logic        a_neg;
      logic [11:0] half_dim;
   } div_flags_type;

endpackage
`default_nettype wire

// ===== rtl/vtpp_sine.sv =====
// Pipelined sine of a Q0.32 turn fraction, signed Q2.16 result, 17 stages.
// Depends on vtpp_pkg.
`default_nettype none
module vtpp_sine (
   input  logic               clock,
   input  logic [31:0]        phase,
   output logic signed [17:0] sine
);

   localparam int unsigned STEPS = vtpp_pkg::SINE_STEPS;

   logic [30:0]        a_ff    [0:STEPS];
   logic [30:0]        term_ff [0:STEPS];
   logic signed [32:0] sum_ff  [0:STEPS];
   logic [1:0]         quad_ff [0:STEPS];

   logic [31:0]        p1_ff [1:STEPS];
   logic [30:0]        a1_ff [1:STEPS];
   logic signed [32:0] s1_ff [1:STEPS];
   logic [1:0]         q1_ff [1:STEPS];

   logic [31:0]        p2_ff [1:STEPS];
   logic [30:0]        a2_ff [1:STEPS];
   logic signed [32:0] s2_ff [1:STEPS];
   logic [1:0]         q2_ff [1:STEPS];

   logic [30:0]        r_in;
   logic [61:0]        a_prod;
   logic signed [33:0] rnd;
   logic [19:0]        mag;
   logic [16:0]        capped;
   logic signed [17:0] sine_ff;

   // fold the quadrant onto the first one and scale to radians
   always_comb begin
      r_in   = phase[30] ? (31'h4000_0000 - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
      a_prod = {31'd0, r_in} * {31'd0, vtpp_pkg::HALF_PI_Q30};
   end

   always_ff @(posedge clock) begin
      a_ff[0]    <= a_prod[60:30];
      term_ff[0] <= a_prod[60:30];
      sum_ff[0]  <= $signed({2'b00, a_prod[60:30]});
      quad_ff[0] <= phase[31:30];
   end

   // one Taylor term per three stages: two products, then a constant divide
   for (genvar k = 1; k <= STEPS; k++) begin : g_step
      localparam int unsigned DIVISOR = 2 * k * (2 * k + 1);
      localparam int unsigned SHIFT   = 32 + $clog2(DIVISOR);
      localparam logic [32:0] RECIP   =
         33'(((65'd1 << SHIFT) + 65'(DIVISOR) - 65'd1) / 65'(DIVISOR));

      logic [61:0] m1;
      logic [62:0] m2;
      logic [64:0] m3;
      logic [30:0] quo;

      assign m1  = {31'd0, term_ff[k-1]} * {31'd0, a_ff[k-1]};
      assign m2  = {31'd0, p1_ff[k]} * {32'd0, a1_ff[k]};
      assign m3  = {33'd0, p2_ff[k]} * {32'd0, RECIP};
      assign quo = 31'(m3 >> SHIFT);

      always_ff @(posedge clock) begin
         p1_ff[k] <= m1[61:30];
         a1_ff[k] <= a_ff[k-1];
         s1_ff[k] <= sum_ff[k-1];
         q1_ff[k] <= quad_ff[k-1];

         p2_ff[k] <= m2[61:30];
         a2_ff[k] <= a1_ff[k];
         s2_ff[k] <= s1_ff[k];
         q2_ff[k] <= q1_ff[k];

         term_ff[k] <= quo;
         a_ff[k]    <= a2_ff[k];
         quad_ff[k] <= q2_ff[k];
         if (k % 2 == 1) begin
            sum_ff[k] <= s2_ff[k] - $signed({2'b00, quo});
         end else begin
            sum_ff[k] <= s2_ff[k] + $signed({2'b00, quo});
         end
      end
   end

   // clamp, round Q2.30 to Q2.16 and restore the sign
   always_comb begin
      rnd    = {sum_ff[STEPS][32], sum_ff[STEPS]} + 34'sd8192;
      mag    = sum_ff[STEPS][32] ? 20'd0 : 20'(rnd >>> 14);
      capped = (mag > 20'd65536) ? 17'd65536 : mag[16:0];
   end

   always_ff @(posedge clock) begin
      if (quad_ff[STEPS][1]) begin
         sine_ff <= -$signed({1'b0, capped});
      end else begin
         sine_ff <= $signed({1'b0, capped});
      end
   end

   assign sine = sine_ff;

endmodule
`default_nettype wire

// ===== rtl/vtpp_div.sv =====
// Pipelined signed projection divide with 16-bit saturation, one quotient
// bit per stage. Depends on vtpp_pkg.
`default_nettype none
module vtpp_div (
   input  logic                          clock,
   input  logic signed [63:0]            num,
   input  logic signed [31:0]            den,
   input  vtpp_pkg::div_flags_type       flags,
   output logic signed [15:0]            quot
);

   localparam int unsigned QB = vtpp_pkg::QUO_BITS;

   logic [62:0]             nmag_ff;
   logic [31:0]             zmag0_ff;
   logic                    neg0_ff;
   logic                    zero0_ff;
   vtpp_pkg::div_flags_type fl0_ff;

   logic [48:0]             r_ff    [0:QB];
   logic [QB-1:0]           q_ff    [0:QB];
   logic [31:0]             zmag_ff [0:QB];
   logic                    neg_ff  [0:QB];
   logic                    zero_ff [0:QB];
   logic                    ovf_ff  [0:QB];
   vtpp_pkg::div_flags_type fl_ff   [0:QB];

   logic [QB-1:0]           m;
   logic signed [15:0]      quot_ff;

   // magnitudes and quotient sign
   always_ff @(posedge clock) begin
      nmag_ff  <= num[63] ? 63'(-num) : num[62:0];
      zmag0_ff <= den[31] ? 32'(-{den[31], den}) : den;
      neg0_ff  <= num[63] ^ den[31];
      zero0_ff <= (den == 32'sd0);
      fl0_ff   <= flags;
   end

   // overflow when the quotient needs more than the kept bits
   always_ff @(posedge clock) begin
      ovf_ff[0]  <= nmag_ff >= {14'd0, zmag0_ff, {QB{1'b0}}};
      r_ff[0]    <= nmag_ff[48:0];
      q_ff[0]    <= '0;
      zmag_ff[0] <= zmag0_ff;
      neg_ff[0]  <= neg0_ff;
      zero_ff[0] <= zero0_ff;
      fl_ff[0]   <= fl0_ff;
   end

   for (genvar j = 0; j < QB; j++) begin : g_bit
      logic [48:0] trial;
      logic        ge;

      assign trial = 49'({17'd0, zmag_ff[j]} << (QB - 1 - j));
      assign ge    = r_ff[j] >= trial;

      always_ff @(posedge clock) begin
         r_ff[j+1]    <= ge ? (r_ff[j] - trial) : r_ff[j];
         q_ff[j+1]    <= {q_ff[j][QB-2:0], ge};
         zmag_ff[j+1] <= zmag_ff[j];
         neg_ff[j+1]  <= neg_ff[j];
         zero_ff[j+1] <= zero_ff[j];
         ovf_ff[j+1]  <= ovf_ff[j];
         fl_ff[j+1]   <= fl_ff[j];
      end
   end

   assign m = q_ff[QB];

   // zero depth, overflow and ordinary saturation
   always_ff @(posedge clock) begin
      if (zero_ff[QB]) begin
         if (fl_ff[QB].a_pos) begin
            quot_ff <= vtpp_pkg::SCREEN_MAX;
         end else if (fl_ff[QB].a_neg) begin
            quot_ff <= vtpp_pkg::SCREEN_MIN;
         end else begin
            quot_ff <= $signed({4'd0, fl_ff[QB].half_dim});
         end
      end else if (ovf_ff[QB]) begin
         quot_ff <= neg_ff[QB] ? vtpp_pkg::SCREEN_MIN : vtpp_pkg::SCREEN_MAX;
      end else if (neg_ff[QB]) begin
         quot_ff <= (m > 17'd32768) ? vtpp_pkg::SCREEN_MIN : 16'(-$signed({1'b0, m}));
      end else begin
         quot_ff <= (m > 17'd32767) ? vtpp_pkg::SCREEN_MAX : $signed(m[15:0]);
      end
   end

   assign quot = quot_ff;

endmodule
`default_nettype wire

// ===== rtl/vertex_transform_perspective_project_unit.sv =====
// Top level of the vertex transform and perspective projection unit.
// Depends on vtpp_pkg, vtpp_sine and vtpp_div.
`default_nettype none
// Usage
//  - Input: a vertex (Q16.16 x, y, z) transfers at a clock edge where start
//    is high and busy is low. One vertex may transfer every cycle while busy is low.
//  - Output: each vertex produces exactly one result, shown for one cycle
//    with rsp_valid high, once it has passed the 6 transform stages and the
//    20-stage projection divider (one quotient bit in each of its 17 bit stages).
//    Results leave in transfer order; the receiver cannot stall them.
//  - Configuration: csr_valid/csr_ready write register csr_index with
//    csr_data; csr_ready is always high. Write only while no vertex is in
//    flight.
//  - Busy: after reset and after every angle_phase write, busy stays high
//    while the sine/cosine pipeline (3 phase stages plus 17 sine stages per
//    lane) settles on the new angle.
//  - Reset: synchronous, clears the pipeline valid bits and loads the
//    register reset values.
module vertex_transform_perspective_project_unit #(
   parameter int unsigned SINE_TABLE_DEPTH = vtpp_pkg::SINE_TABLE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_vertex_x,
   input  logic signed [31:0] req_vertex_y,
   input  logic signed [31:0] req_vertex_z,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_screen_x,
   output logic signed [15:0] rsp_screen_y,
   output logic signed [31:0] rsp_depth,
   output logic               rsp_in_front,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   // Angle to turn fraction: t = floor(idx * 2^32 / DEPTH), split into
   // idx*Q + floor(idx*R / DEPTH) with a reciprocal for the small divide.
   localparam int unsigned IDX_W       = $clog2(SINE_TABLE_DEPTH);
   localparam int unsigned APROD_W     = 16 + $clog2(SINE_TABLE_DEPTH + 1);
   localparam logic [63:0] TURN_Q      = (64'd1 << 32) / SINE_TABLE_DEPTH;
   localparam logic [63:0] TURN_R      = (64'd1 << 32) % SINE_TABLE_DEPTH;
   localparam int unsigned REM_W       = 2 * IDX_W;
   localparam int unsigned RECIP_W     = REM_W + 1;
   localparam int unsigned RECIP_SHIFT = REM_W + IDX_W;
   localparam logic [63:0] RECIP       =
      ((64'd1 << RECIP_SHIFT) + 64'(SINE_TABLE_DEPTH) - 64'd1) / SINE_TABLE_DEPTH;
   localparam int unsigned DL          = vtpp_pkg::DIV_LATENCY;

   function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
      logic signed [71:0] hi;
      logic signed [71:0] lo;
      hi = 72'sh7fff_ffff;
      lo = -72'sh8000_0000;
      if (v > hi) begin
         return 32'sh7fff_ffff;
      end else if (v < lo) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [15:0]        angle_ff;
   logic [31:0]        scale_ff;
   logic signed [31:0] off_x_ff;
   logic signed [31:0] off_y_ff;
   logic signed [31:0] off_z_ff;
   logic [31:0]        fov_ff;
   logic [12:0]        width_ff;
   logic [12:0]        height_ff;
   logic [vtpp_pkg::SETTLE_W-1:0] settle_ff;
   logic               csr_write;
   logic               angle_write;

   assign csr_ready   = 1'b1;
   assign csr_write   = csr_valid && csr_ready;
   assign angle_write = csr_write && (csr_index == vtpp_pkg::REG_ANGLE_PHASE);

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff  <= vtpp_pkg::ANGLE_RESET;
         scale_ff  <= vtpp_pkg::SCALE_RESET;
         off_x_ff  <= vtpp_pkg::OFFSET_RESET;
         off_y_ff  <= vtpp_pkg::OFFSET_RESET;
         off_z_ff  <= vtpp_pkg::OFFSET_RESET;
         fov_ff    <= vtpp_pkg::FOV_RESET;
         width_ff  <= vtpp_pkg::WIDTH_RESET;
         height_ff <= vtpp_pkg::HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            vtpp_pkg::REG_ANGLE_PHASE:   angle_ff  <= csr_data[15:0];
            vtpp_pkg::REG_SCALE_FACTOR:  scale_ff  <= csr_data;
            vtpp_pkg::REG_OFFSET_X:      off_x_ff  <= csr_data;
            vtpp_pkg::REG_OFFSET_Y:      off_y_ff  <= csr_data;
            vtpp_pkg::REG_OFFSET_Z:      off_z_ff  <= csr_data;
            vtpp_pkg::REG_FOV_FACTOR:    fov_ff    <= csr_data;
            vtpp_pkg::REG_WINDOW_WIDTH:  width_ff  <= csr_data[12:0];
            vtpp_pkg::REG_WINDOW_HEIGHT: height_ff <= csr_data[12:0];
            default: ;
         endcase
      end
   end

   // hold busy until the trig pipeline reflects the current angle
   always_ff @(posedge clock) begin
      if (reset || angle_write) begin
         settle_ff <= vtpp_pkg::SETTLE_CYCLES;
      end else if (settle_ff != '0) begin
         settle_ff <= settle_ff - 1'b1;
      end
   end

   assign busy = reset || (settle_ff != '0);

   // ------------------------------------------------------------------
   // Sine / cosine: free-running from the angle register
   // ------------------------------------------------------------------
   logic [APROD_W-1:0]             aprod;
   logic [IDX_W-1:0]               idx_ff;
   logic [31:0]                    iq_ff;
   logic [REM_W-1:0]               ir_ff;
   logic [REM_W+RECIP_W-1:0]       frac_prod;
   logic [31:0]                    frac;
   logic [31:0]                    t_sin_ff;
   logic [31:0]                    t_cos_ff;
   logic signed [vtpp_pkg::TRIG_W-1:0] sin_v;
   logic signed [vtpp_pkg::TRIG_W-1:0] cos_v;

   always_comb begin
      aprod     = {{(APROD_W-16){1'b0}}, angle_ff} * APROD_W'(SINE_TABLE_DEPTH);
      frac_prod = {{RECIP_W{1'b0}}, ir_ff} * {{REM_W{1'b0}}, RECIP_W'(RECIP)};
      frac      = 32'(frac_prod >> RECIP_SHIFT);
   end

   always_ff @(posedge clock) begin
      idx_ff   <= IDX_W'(aprod >> 16);
      iq_ff    <= 32'({{(32-IDX_W){1'b0}}, idx_ff} * TURN_Q[31:0]);
      ir_ff    <= REM_W'({{IDX_W{1'b0}}, idx_ff} * REM_W'(TURN_R));
      t_sin_ff <= iq_ff + frac;
      t_cos_ff <= iq_ff + frac + 32'h4000_0000;
   end

   vtpp_sine u_sin (
      .clock (clock),
      .phase (t_sin_ff),
      .sine  (sin_v)
   );

   vtpp_sine u_cos (
      .clock (clock),
      .phase (t_cos_ff),
      .sine  (cos_v)
   );

   // ------------------------------------------------------------------
   // Transform pipeline
   // ------------------------------------------------------------------
   logic take;
   assign take = start && !busy;

   // stage 1: rotation products
   logic               vld1_ff;
   logic signed [49:0] xc1_ff, xs1_ff, zc1_ff, zs1_ff;
   logic signed [31:0] y1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else begin
         vld1_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      xc1_ff <= req_vertex_x * cos_v;
      xs1_ff <= req_vertex_x * sin_v;
      zc1_ff <= req_vertex_z * cos_v;
      zs1_ff <= req_vertex_z * sin_v;
      y1_ff  <= req_vertex_y;
   end

   // stage 2: rotated coordinates, floor shift and saturate
   logic               vld2_ff;
   logic signed [31:0] rx2_ff, rz2_ff, y2_ff;
   logic signed [50:0] rx_sum, rz_sum;

   always_comb begin
      rx_sum = {xc1_ff[49], xc1_ff} + {zs1_ff[49], zs1_ff};
      rz_sum = {zc1_ff[49], zc1_ff} - {xs1_ff[49], xs1_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld2_ff <= 1'b0;
      end else begin
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      rx2_ff <= sat32(72'(rx_sum >>> 16));
      rz2_ff <= sat32(72'(rz_sum >>> 16));
      y2_ff  <= y1_ff;
   end

   // stage 3: scale products
   logic               vld3_ff;
   logic signed [64:0] px3_ff, py3_ff, pz3_ff;
   logic signed [32:0] scale_s;

   assign scale_s = $signed({1'b0, scale_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         vld3_ff <= 1'b0;
      end else begin
         vld3_ff <= vld2_ff;
      end
   end

   always_ff @(posedge clock) begin
      px3_ff <= rx2_ff * scale_s;
      py3_ff <= y2_ff * scale_s;
      pz3_ff <= rz2_ff * scale_s;
   end

   // stage 4: shift, saturate, translate, saturate
   logic               vld4_ff;
   logic signed [31:0] x4_ff, y4_ff, z4_ff;
   logic signed [31:0] sx, sy, sz;
   logic signed [32:0] tx, ty, tz;

   always_comb begin
      sx = sat32(72'(px3_ff >>> 16));
      sy = sat32(72'(py3_ff >>> 16));
      sz = sat32(72'(pz3_ff >>> 16));
      tx = {sx[31], sx} + {off_x_ff[31], off_x_ff};
      ty = {sy[31], sy} + {off_y_ff[31], off_y_ff};
      tz = {sz[31], sz} + {off_z_ff[31], off_z_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld4_ff <= 1'b0;
      end else begin
         vld4_ff <= vld3_ff;
      end
   end

   always_ff @(posedge clock) begin
      x4_ff <= sat32(72'(tx));
      y4_ff <= sat32(72'(ty));
      z4_ff <= sat32(72'(tz));
   end

   // stage 5: field of view products and window constants
   logic               vld5_ff;
   logic signed [48:0] ax5_ff, ay5_ff;
   logic signed [31:0] z5_ff;
   logic [12:0]        large5_ff;
   logic [11:0]        hw5_ff, hh5_ff;
   logic signed [64:0] fx, fy;
   logic signed [32:0] fov_s;

   assign fov_s = $signed({1'b0, fov_ff});

   always_comb begin
      fx = x4_ff * fov_s;
      fy = y4_ff * fov_s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld5_ff <= 1'b0;
      end else begin
         vld5_ff <= vld4_ff;
      end
   end

   always_ff @(posedge clock) begin
      ax5_ff    <= 49'(fx >>> 16);
      ay5_ff    <= 49'(fy >>> 16);
      z5_ff     <= z4_ff;
      large5_ff <= (width_ff > height_ff) ? width_ff : height_ff;
      hw5_ff    <= width_ff[12:1];
      hh5_ff    <= height_ff[12:1];
   end

   // stage 6: projection numerators
   logic                    vld6_ff;
   logic signed [63:0]      nx6_ff, ny6_ff;
   logic signed [31:0]      z6_ff;
   vtpp_pkg::div_flags_type fx6_ff, fy6_ff;
   logic signed [63:0]      lx, ly, hzx, hzy;
   logic signed [13:0]      large_s;

   assign large_s = $signed({1'b0, large5_ff});

   always_comb begin
      lx  = ax5_ff * large_s;
      ly  = ay5_ff * large_s;
      hzx = $signed({1'b0, hw5_ff}) * z5_ff;
      hzy = $signed({1'b0, hh5_ff}) * z5_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld6_ff <= 1'b0;
      end else begin
         vld6_ff <= vld5_ff;
      end
   end

   always_ff @(posedge clock) begin
      nx6_ff          <= lx + hzx;
      ny6_ff          <= ly + hzy;
      z6_ff           <= z5_ff;
      fx6_ff.a_pos    <= ax5_ff > 49'sd0;
      fx6_ff.a_neg    <= ax5_ff[48];
      fx6_ff.half_dim <= hw5_ff;
      fy6_ff.a_pos    <= ay5_ff > 49'sd0;
      fy6_ff.a_neg    <= ay5_ff[48];
      fy6_ff.half_dim <= hh5_ff;
   end

   // ------------------------------------------------------------------
   // Projection divide, with valid and depth delayed alongside
   // ------------------------------------------------------------------
   logic signed [15:0] qx, qy;
   logic               vld_dly_ff [0:DL-1];
   logic signed [31:0] z_dly_ff   [0:DL-1];

   vtpp_div u_div_x (
      .clock (clock),
      .num   (nx6_ff),
      .den   (z6_ff),
      .flags (fx6_ff),
      .quot  (qx)
   );

   vtpp_div u_div_y (
      .clock (clock),
      .num   (ny6_ff),
      .den   (z6_ff),
      .flags (fy6_ff),
      .quot  (qy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DL; i++) begin
            vld_dly_ff[i] <= 1'b0;
         end
      end else begin
         vld_dly_ff[0] <= vld6_ff;
         for (int i = 1; i < DL; i++) begin
            vld_dly_ff[i] <= vld_dly_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      z_dly_ff[0] <= z6_ff;
      for (int i = 1; i < DL; i++) begin
         z_dly_ff[i] <= z_dly_ff[i-1];
      end
   end

   assign rsp_valid    = vld_dly_ff[DL-1];
   assign rsp_screen_x = qx;
   assign rsp_screen_y = qy;
   assign rsp_depth    = z_dly_ff[DL-1];
   assign rsp_in_front = z_dly_ff[DL-1] > 32'sd0;

`ifndef NO_ASSERTIONS
   // every transfer yields a result after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      take |-> ##(vtpp_pkg::LATENCY) rsp_valid)
      else $error("result missing after vertex transfer");

   // no result without a transfer the fixed latency earlier
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(take, vtpp_pkg::LATENCY))
      else $error("result without matching vertex transfer");

   // an angle change blocks transfers while the trig path settles
   a_settle: assert property (@(posedge clock) disable iff (reset)
      angle_write |=> busy)
      else $error("not busy after angle write");
`endif

endmodule
`default_nettype wire

// ===== dv/vertex_transform_perspective_project_unit_tb.sv =====
// Self-checking testbench for the vertex transform and perspective projection unit.
// Depends on vtpp_pkg and vertex_transform_perspective_project_unit; reads no files.
`default_nettype none
module vertex_transform_perspective_project_unit_tb;

   localparam int unsigned TABLE_DEPTH = 1024;
   localparam int unsigned QUIET_LIMIT = 20000;

   typedef enum logic [1:0] {ITEM_VERTEX, ITEM_CSR, ITEM_DRAIN} item_kind_type;

   typedef struct {
      item_kind_type kind;
      logic [2:0]  idx;
      logic [31:0] data;
      logic signed [31:0] vx, vy, vz;
   } pending_item_type;

   typedef struct {
      logic signed [15:0] sx, sy;
      logic signed [31:0] depth;
      logic               front;
   } projection_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [31:0] req_vertex_x = '0, req_vertex_y = '0, req_vertex_z = '0;
   logic rsp_valid;
   logic signed [15:0] rsp_screen_x, rsp_screen_y;
   logic signed [31:0] rsp_depth;
   logic rsp_in_front;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   vertex_transform_perspective_project_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_vertex_x(req_vertex_x), .req_vertex_y(req_vertex_y),
      .req_vertex_z(req_vertex_z), .rsp_valid(rsp_valid),
      .rsp_screen_x(rsp_screen_x), .rsp_screen_y(rsp_screen_y),
      .rsp_depth(rsp_depth), .rsp_in_front(rsp_in_front),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Shadow copy of the configuration registers
   longint cfg_angle, cfg_scale, cfg_off_x, cfg_off_y, cfg_off_z, cfg_fov, cfg_w, cfg_h;

   pending_item_type pending_q[$];
   projection_type   projection_q[$];

   int  errors = 0;
   int  vertex_count = 0, result_count = 0, csr_count = 0, zero_depth_count = 0;
   int  quiet = 0;
   int  gap = 0;
   bit  no_idle = 0;
   bit  req_fire = 0, csr_fire = 0;
   bit  stimulus_done = 0;

   function automatic longint sat_range(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint sat32(longint v);
      return sat_range(v, -64'sd2147483648, 64'sd2147483647);
   endfunction

   // Quarter-wave sine by an odd Taylor series in Q2.30, rounded to Q16.16
   function automatic longint sine_q16(logic [31:0] t);
      longint unsigned r, a, term;
      longint sum, v;
      r = t[29:0];
      if (t[30]) r = 64'h4000_0000 - r;
      a = (r * 64'd1686629713) >> 30;
      term = a;
      sum = longint'(a);
      for (int k = 1; k <= 5; k++) begin
         term = (((term * a) >> 30) * a) >> 30;
         term = term / longint'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      v = (sum + 8192) >>> 14;
      if (v > 65536) v = 65536;
      return t[31] ? -v : v;
   endfunction

   function automatic longint project_axis(longint a, longint z, longint lg, longint dim);
      if (z == 0) begin
         if (a > 0) return 32767;
         if (a < 0) return -32768;
         return sat_range(dim >>> 1, -32768, 32767);
      end
      return sat_range((a * lg + (dim >>> 1) * z) / z, -32768, 32767);
   endfunction

   function automatic projection_type project_vertex(logic signed [31:0] vx,
                                                     logic signed [31:0] vy,
                                                     logic signed [31:0] vz);
      longint unsigned step;
      logic [31:0] t;
      longint sn, cs, x, y, z, rx, rz, bx, by, bz, ax, ay, lg;
      projection_type p;
      x = vx; y = vy; z = vz;
      step = (longint'(cfg_angle) * TABLE_DEPTH) >> 16;
      t = 32'((step << 32) / TABLE_DEPTH);
      sn = sine_q16(t);
      cs = sine_q16(t + 32'h4000_0000);
      rx = sat32((x * cs + z * sn) >>> 16);
      rz = sat32((z * cs - x * sn) >>> 16);
      bx = sat32(sat32((rx * cfg_scale) >>> 16) + cfg_off_x);
      by = sat32(sat32((y * cfg_scale) >>> 16) + cfg_off_y);
      bz = sat32(sat32((rz * cfg_scale) >>> 16) + cfg_off_z);
      lg = cfg_w > cfg_h ? cfg_w : cfg_h;
      ax = (bx * cfg_fov) >>> 16;
      ay = (by * cfg_fov) >>> 16;
      p.sx = 16'(project_axis(ax, bz, lg, cfg_w));
      p.sy = 16'(project_axis(ay, bz, lg, cfg_h));
      p.depth = 32'(bz);
      p.front = bz > 0;
      return p;
   endfunction

   task automatic apply_register(logic [2:0] idx, logic [31:0] data);
      case (idx)
         vtpp_pkg::REG_ANGLE_PHASE:   cfg_angle = data[15:0];
         vtpp_pkg::REG_SCALE_FACTOR:  cfg_scale = longint'({32'b0, data});
         vtpp_pkg::REG_OFFSET_X:      cfg_off_x = longint'(signed'(data));
         vtpp_pkg::REG_OFFSET_Y:      cfg_off_y = longint'(signed'(data));
         vtpp_pkg::REG_OFFSET_Z:      cfg_off_z = longint'(signed'(data));
         vtpp_pkg::REG_FOV_FACTOR:    cfg_fov   = longint'({32'b0, data});
         vtpp_pkg::REG_WINDOW_WIDTH:  cfg_w     = data[12:0];
         default:                     cfg_h     = data[12:0];
      endcase
   endtask

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Monitor: record transfers, predict on accepted vertices, check results
   always @(posedge clock) begin
      projection_type exp_p;
      bit active;
      active = 0;
      if (reset) begin
         req_fire <= 0;
         csr_fire <= 0;
      end else begin
         req_fire <= start && !busy;
         csr_fire <= csr_valid && csr_ready;
         if (csr_valid && csr_ready) begin
            apply_register(csr_index, csr_data);
            csr_count++;
            active = 1;
         end
         if (start && !busy) begin
            projection_q.push_back(project_vertex(req_vertex_x, req_vertex_y, req_vertex_z));
            vertex_count++;
            active = 1;
         end
         if (rsp_valid) begin
            active = 1;
            if (projection_q.size() == 0) begin
               $error("result with nothing expected");
               errors++;
            end else begin
               exp_p = projection_q.pop_front();
               result_count++;
               if (exp_p.depth == 0) zero_depth_count++;
               if (rsp_screen_x !== exp_p.sx) begin
                  $error("screen_x expected %0d got %0d", exp_p.sx, rsp_screen_x);
                  errors++;
               end
               if (rsp_screen_y !== exp_p.sy) begin
                  $error("screen_y expected %0d got %0d", exp_p.sy, rsp_screen_y);
                  errors++;
               end
               if (rsp_depth !== exp_p.depth) begin
                  $error("depth expected %0d got %0d", exp_p.depth, rsp_depth);
                  errors++;
               end
               if (rsp_in_front !== exp_p.front) begin
                  $error("in_front expected %0b got %0b", exp_p.front, rsp_in_front);
                  errors++;
               end
            end
         end
         quiet <= active ? 0 : quiet + 1;
      end
   end

   // Driver: offer the head of the pending queue at the falling edge
   always @(negedge clock) begin
      logic nxt_start, nxt_csr;
      pending_item_type it;
      nxt_start = 0;
      nxt_csr = 0;
      if (!reset) begin
         if ((start && req_fire) || (csr_valid && csr_fire)) begin
            void'(pending_q.pop_front());
            gap = pick_gap();
         end
         if (start && !req_fire) nxt_start = 1;            // hold until transfer
         else if (csr_valid && !csr_fire) nxt_csr = 1;
         else if (gap > 0) gap--;
         else if (pending_q.size() > 0) begin
            it = pending_q[0];
            case (it.kind)
               ITEM_VERTEX: begin
                  nxt_start = 1;
                  req_vertex_x <= it.vx;
                  req_vertex_y <= it.vy;
                  req_vertex_z <= it.vz;
               end
               // write registers only once the pipeline has fully drained
               ITEM_CSR: if (projection_q.size() == 0 && quiet >= 4) begin
                  nxt_csr = 1;
                  csr_index <= it.idx;
                  csr_data <= it.data;
               end
               default: if (projection_q.size() == 0) void'(pending_q.pop_front());
            endcase
         end
      end
      start <= nxt_start;
      csr_valid <= nxt_csr;
      if (!reset && pending_q.size() == 0 && !nxt_start && !nxt_csr) stimulus_done = 1;
   end

   function automatic logic [31:0] pick_coord();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 25) return $urandom();
      if (roll < 75) return 32'($signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000);
      if (roll < 90) begin
         case ($urandom_range(0, 3))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'hffff_ffff;
            default: return 32'h0001_0000;
         endcase
      end
      return 32'h0;
   endfunction

   task automatic queue_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      pending_item_type it;
      it.kind = ITEM_VERTEX; it.idx = '0; it.data = '0;
      it.vx = x; it.vy = y; it.vz = z;
      pending_q.push_back(it);
   endtask

   task automatic queue_csr(logic [2:0] idx, logic [31:0] data);
      pending_item_type it;
      it.kind = ITEM_CSR; it.idx = idx; it.data = data;
      it.vx = '0; it.vy = '0; it.vz = '0;
      pending_q.push_back(it);
   endtask

   task automatic queue_drain();
      pending_item_type it;
      it.kind = ITEM_DRAIN; it.idx = '0; it.data = '0;
      it.vx = '0; it.vy = '0; it.vz = '0;
      pending_q.push_back(it);
   endtask

   // Write all eight registers: mode 0 random moderate, 1 mostly maxima, 2 mostly minima
   task automatic queue_settings(int mode);
      if (mode == 1) begin
         queue_csr(vtpp_pkg::REG_ANGLE_PHASE, 32'hffff_ffff);
         queue_csr(vtpp_pkg::REG_SCALE_FACTOR, 32'hffff_ffff);
         queue_csr(vtpp_pkg::REG_OFFSET_X, 32'h7fff_ffff);
         queue_csr(vtpp_pkg::REG_OFFSET_Y, 32'h7fff_ffff);
         queue_csr(vtpp_pkg::REG_OFFSET_Z, 32'h7fff_ffff);
         queue_csr(vtpp_pkg::REG_FOV_FACTOR, 32'hffff_ffff);
         queue_csr(vtpp_pkg::REG_WINDOW_WIDTH, 32'd8191);
         queue_csr(vtpp_pkg::REG_WINDOW_HEIGHT, 32'd4096);
      end else if (mode == 2) begin
         queue_csr(vtpp_pkg::REG_ANGLE_PHASE, 32'd0);
         queue_csr(vtpp_pkg::REG_SCALE_FACTOR, 32'd0);
         queue_csr(vtpp_pkg::REG_OFFSET_X, 32'h8000_0000);
         queue_csr(vtpp_pkg::REG_OFFSET_Y, 32'h8000_0000);
         queue_csr(vtpp_pkg::REG_OFFSET_Z, 32'h8000_0000);
         queue_csr(vtpp_pkg::REG_FOV_FACTOR, 32'd0);
         queue_csr(vtpp_pkg::REG_WINDOW_WIDTH, 32'd0);
         queue_csr(vtpp_pkg::REG_WINDOW_HEIGHT, 32'd1);
      end else begin
         queue_csr(vtpp_pkg::REG_ANGLE_PHASE, $urandom());
         queue_csr(vtpp_pkg::REG_SCALE_FACTOR, $urandom_range(32'h0000_4000, 32'h0004_0000));
         queue_csr(vtpp_pkg::REG_OFFSET_X,
                   32'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000));
         queue_csr(vtpp_pkg::REG_OFFSET_Y,
                   32'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000));
         // occasionally no Z offset, so vertices with zero Z hit zero depth
         queue_csr(vtpp_pkg::REG_OFFSET_Z, $urandom_range(0, 3) == 0 ? 32'h0 :
                   $urandom_range(32'h0001_0000, 32'h0100_0000));
         queue_csr(vtpp_pkg::REG_FOV_FACTOR, $urandom_range(32'h0000_4000, 32'h0004_0000));
         queue_csr(vtpp_pkg::REG_WINDOW_WIDTH, $urandom_range(1, 4096));
         queue_csr(vtpp_pkg::REG_WINDOW_HEIGHT, $urandom_range(1, 4096));
      end
   endtask

   initial begin
      int cycles;
      cfg_angle = vtpp_pkg::ANGLE_RESET; cfg_scale = vtpp_pkg::SCALE_RESET;
      cfg_off_x = 0; cfg_off_y = 0; cfg_off_z = 0; cfg_fov = vtpp_pkg::FOV_RESET;
      cfg_w = vtpp_pkg::WIDTH_RESET; cfg_h = vtpp_pkg::HEIGHT_RESET;

      // Directed: reset defaults, field extremes, zero depth on both signs
      queue_vertex(32'h0, 32'h0, 32'h0);
      queue_vertex(32'h0001_0000, 32'hffff_0000, 32'h0);
      queue_vertex(32'hffff_0000, 32'h0001_0000, 32'h0);
      queue_vertex(32'h0001_0000, 32'h0002_0000, 32'h000a_0000);
      queue_vertex(32'h0001_0000, 32'h0002_0000, 32'hfff6_0000);
      queue_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      queue_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      queue_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
      queue_vertex(32'h0000_0001, 32'hffff_ffff, 32'h0000_0001);
      queue_vertex(32'h0064_0000, 32'h0064_0000, 32'h0000_0100);
      queue_drain();
      // quarter-turn angles through sine table corners
      queue_csr(vtpp_pkg::REG_ANGLE_PHASE, 32'h4000);
      queue_vertex(32'h0003_0000, 32'h0001_0000, 32'h0005_0000);
      queue_vertex(32'h0000_0000, 32'h0001_0000, 32'h0005_0000);
      queue_csr(vtpp_pkg::REG_ANGLE_PHASE, 32'h8000);
      queue_vertex(32'h0003_0000, 32'h0001_0000, 32'hfffb_0000);
      queue_csr(vtpp_pkg::REG_ANGLE_PHASE, 32'hc000);
      queue_vertex(32'h0003_0000, 32'h0001_0000, 32'h0005_0000);
      queue_csr(vtpp_pkg::REG_ANGLE_PHASE, 32'hffff);
      queue_vertex(32'h0003_0000, 32'h0001_0000, 32'h0005_0000);
      queue_settings(1);
      queue_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      queue_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
      queue_settings(2);
      queue_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      queue_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);

      // Random phases, each under its own register settings
      for (int ph = 0; ph < 8; ph++) begin
         queue_settings(ph == 3 ? 1 : (ph == 6 ? 2 : 0));
         for (int n = 0; n < 195; n++) begin
            if (n == 97) queue_drain();              // hold off until the pipe empties
            queue_vertex(pick_coord(), pick_coord(),
                         $urandom_range(0, 9) == 0 ? 32'h0 : pick_coord());
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Flip between idling and back-to-back stretches until all is sent
      cycles = 0;
      while (!stimulus_done && quiet < QUIET_LIMIT) begin
         @(posedge clock);
         cycles++;
         if (cycles % 300 == 0) no_idle = !no_idle;
      end
      while (projection_q.size() > 0 && quiet < QUIET_LIMIT) @(posedge clock);
      if (quiet >= QUIET_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         repeat (vtpp_pkg::LATENCY + 10) @(posedge clock);
         $display("covered %0d vertices, %0d results (%0d at zero depth), %0d register writes",
                  vertex_count, result_count, zero_depth_count, csr_count);
         if (errors == 0 && projection_q.size() == 0) begin
            $display("*** PASSED ***");
         end else begin
            $display("*** FAILED ***");
         end
         $finish;
      end
   end
endmodule
`default_nettype wire
